// File: src/lms_pkg.sv
`timescale 1ns / 1ps

package lms_pkg;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_RENDER = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REGION_OTHER = 2'd0,
      REGION_VRAM  = 2'd1,
      REGION_OAM   = 2'd2,
      REGION_NONE  = 2'd3
   } region_type;

   localparam int CYCLE_W = 10;
   localparam int LINE_W  = 8;
   localparam int ADDR_W  = 16;
   localparam int COUNT_W = 8;

   localparam logic [ADDR_W-1:0] VRAM_LO = 16'h8000;
   localparam logic [ADDR_W-1:0] VRAM_HI = 16'h9FFF;
   localparam logic [ADDR_W-1:0] OAM_LO  = 16'hFE00;
   localparam logic [ADDR_W-1:0] OAM_HI  = 16'hFE9F;

   localparam logic [7:0] BLOCKED_READ_DATA = 8'hFF;

   typedef struct packed {
      mode_type              mode;
      logic [CYCLE_W-1:0]    cycles;
      logic [LINE_W-1:0]     line;
   } state_type;

   typedef struct packed {
      logic [1:0]            mode;
      logic [LINE_W-1:0]     scan_line;
      logic                  vblank_interrupt;
      logic                  start_sprite_search;
      logic                  draw_line_now;
      logic [1:0]            access_region;
      logic                  access_blocked;
   } result_type;

   typedef struct packed {
      logic [1:0]            operation;
      logic [COUNT_W-1:0]    cycle_count;
      logic [ADDR_W-1:0]     bus_address;
   } item_type;

endpackage

// File: src/lms_if.sv
`timescale 1ns / 1ps

interface lms_req_if;
   import lms_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           operation;
   logic [COUNT_W-1:0]   cycle_count;
   logic [ADDR_W-1:0]    bus_address;

   modport source (output valid, output operation, output cycle_count,
                   output bus_address, input ready);
   modport sink   (input valid, input operation, input cycle_count,
                   input bus_address, output ready);
endinterface

interface lms_rsp_if;
   import lms_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           mode;
   logic [LINE_W-1:0]    scan_line;
   logic                 vblank_interrupt;
   logic                 start_sprite_search;
   logic                 draw_line_now;
   logic [1:0]           access_region;
   logic                 access_blocked;

   modport source (output valid, output mode, output scan_line, output vblank_interrupt,
                   output start_sprite_search, output draw_line_now,
                   output access_region, output access_blocked, input ready);
   modport sink   (input valid, input mode, input scan_line, input vblank_interrupt,
                   input start_sprite_search, input draw_line_now,
                   input access_region, input access_blocked, output ready);
endinterface

interface lms_csr_if;
   logic valid;
   logic ready;
   logic display_enable;

   modport source (output valid, output display_enable, input ready);
   modport sink   (input valid, input display_enable, output ready);
endinterface

// File: src/lms_region.sv
`timescale 1ns / 1ps

module lms_region
   import lms_pkg::*;
(
   input  logic [ADDR_W-1:0] bus_address,
   output region_type        region
);

   always_comb begin
      if (bus_address >= VRAM_LO && bus_address <= VRAM_HI) begin
         region = REGION_VRAM;
      end else if (bus_address >= OAM_LO && bus_address <= OAM_HI) begin
         region = REGION_OAM;
      end else begin
         region = REGION_OTHER;
      end
   end

endmodule

// File: src/lms_step.sv
`timescale 1ns / 1ps

module lms_step
   import lms_pkg::*;
#(
   parameter int VISIBLE_LINES = 144,
   parameter int TOTAL_LINES   = 154,
   parameter int SEARCH_CYCLES = 80,
   parameter int RENDER_CYCLES = 172,
   parameter int HBLANK_CYCLES = 204,
   parameter int LINE_CYCLES   = 456
) (
   input  state_type  cur,
   input  item_type   item,
   input  logic       enable,
   output state_type  nxt,
   output result_type result
);

   localparam logic [CYCLE_W-1:0] SEARCH_LIM = CYCLE_W'(SEARCH_CYCLES);
   localparam logic [CYCLE_W-1:0] RENDER_LIM = CYCLE_W'(RENDER_CYCLES);
   localparam logic [CYCLE_W-1:0] HBLANK_LIM = CYCLE_W'(HBLANK_CYCLES);
   localparam logic [CYCLE_W-1:0] LINE_LIM   = CYCLE_W'(LINE_CYCLES);
   localparam logic [LINE_W-1:0]  VIS_LIM    = LINE_W'(VISIBLE_LINES);
   localparam logic [LINE_W-1:0]  TOT_LIM    = LINE_W'(TOTAL_LINES);

   region_type         region;
   logic [CYCLE_W-1:0] sum;
   logic               vbi;
   logic               srch;
   logic               draw;
   logic               blocked;
   region_type         region_out;

   lms_region u_region (
      .bus_address (item.bus_address),
      .region      (region)
   );

   assign sum = cur.cycles + {{(CYCLE_W-COUNT_W){1'b0}}, item.cycle_count};

   always_comb begin
      nxt        = cur;
      vbi        = 1'b0;
      srch       = 1'b0;
      draw       = 1'b0;
      blocked    = 1'b0;
      region_out = REGION_OTHER;
      case (op_type'(item.operation))
         OP_TICK: begin
            if (!enable) begin
               nxt.mode   = MODE_HBLANK;
               nxt.cycles = '0;
               nxt.line   = '0;
            end else begin
               nxt.cycles = sum;
               case (cur.mode)
                  MODE_SEARCH: begin
                     if (sum >= SEARCH_LIM) begin
                        nxt.mode   = MODE_RENDER;
                        nxt.cycles = '0;
                        srch       = 1'b1;
                     end
                  end
                  MODE_RENDER: begin
                     if (sum >= RENDER_LIM) begin
                        nxt.mode   = MODE_HBLANK;
                        nxt.cycles = '0;
                        nxt.line   = cur.line + 1'b1;
                        draw       = 1'b1;
                     end
                  end
                  MODE_HBLANK: begin
                     if (sum >= HBLANK_LIM) begin
                        nxt.cycles = '0;
                        if (cur.line >= VIS_LIM) begin
                           nxt.mode = MODE_VBLANK;
                           vbi      = 1'b1;
                        end else begin
                           nxt.mode = MODE_SEARCH;
                        end
                     end
                  end
                  default: begin
                     if (sum >= LINE_LIM) begin
                        nxt.cycles = '0;
                        nxt.line   = cur.line + 1'b1;
                     end
                     if (nxt.line >= TOT_LIM) begin
                        nxt.mode = MODE_SEARCH;
                        nxt.line = '0;
                     end
                  end
               endcase
            end
         end
         OP_READ, OP_WRITE: begin
            region_out = region;
            if (enable) begin
               if (cur.mode == MODE_SEARCH && region == REGION_OAM) begin
                  blocked = 1'b1;
               end
               if (cur.mode == MODE_RENDER && region != REGION_OTHER) begin
                  blocked = 1'b1;
               end
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   always_comb begin
      result.mode                = nxt.mode;
      result.scan_line           = nxt.line;
      result.vblank_interrupt    = vbi;
      result.start_sprite_search = srch;
      result.draw_line_now       = draw;
      result.access_region       = region_out;
      result.access_blocked      = blocked;
   end

endmodule

// File: src/lcd_mode_sequencer_core.sv
`timescale 1ns / 1ps
// display controller mode sequencer
// req_chan carries one word per item: a tick (operation 0) advancing the mode
// timing by cycle_count, or a read/write access check (1/2) of bus_address.
// rsp_chan returns one word per item: mode and scan line after the step, the
// vblank, sprite search and draw line pulses, and the access region and
// blocked flag.
// csr_chan writes display_enable; it is always ready. the user must write it
// only while the block is idle; the block itself does not enforce this. with
// display_enable low, each tick returns the sequencer to hblank, line 0,
// counter 0. a word accepted from req_chan goes into the input register,
// then through the step logic into the result register, where rsp_chan
// valid rises. throughput: one word per cycle while rsp_chan does not stall,
// as the mode, counter and line state are updated for each word as it moves
// from the input register to the result register.
// when rsp_chan stalls, the result register holds and the input register
// still takes one more word; req_chan ready drops once both are full.
// reset clears the state, display_enable and both stages' valid flags.
module lcd_mode_sequencer_core
   import lms_pkg::*;
#(
   parameter int VISIBLE_LINES = 144,
   parameter int TOTAL_LINES   = 154,
   parameter int SEARCH_CYCLES = 80,
   parameter int RENDER_CYCLES = 172,
   parameter int HBLANK_CYCLES = 204,
   parameter int LINE_CYCLES   = 456
) (
   input  logic      clock,
   input  logic      reset,
   lms_req_if.sink   req_chan,
   lms_rsp_if.source rsp_chan,
   lms_csr_if.sink   csr_chan
);

   logic       enable_ff;
   logic       enable_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   item_ff;
   item_type   item_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type result_ff;
   result_type result_in;
   state_type  state_ff;
   state_type  state_in;
   state_type  state_nxt;
   result_type step_result;
   logic       advance;
   logic       take;

   lms_step #(
      .VISIBLE_LINES (VISIBLE_LINES),
      .TOTAL_LINES   (TOTAL_LINES),
      .SEARCH_CYCLES (SEARCH_CYCLES),
      .RENDER_CYCLES (RENDER_CYCLES),
      .HBLANK_CYCLES (HBLANK_CYCLES),
      .LINE_CYCLES   (LINE_CYCLES)
   ) u_step (
      .cur    (state_ff),
      .item   (item_ff),
      .enable (enable_ff),
      .nxt    (state_nxt),
      .result (step_result)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      enable_in    = enable_ff;
      in_valid_in  = in_valid_ff;
      item_in      = item_ff;
      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      state_in     = state_ff;
      if (csr_chan.valid) begin
         enable_in = csr_chan.display_enable;
      end
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         result_in    = step_result;
         state_in     = state_nxt;
      end
      if (take) begin
         in_valid_in          = 1'b1;
         item_in.operation    = req_chan.operation;
         item_in.cycle_count  = req_chan.cycle_count;
         item_in.bus_address  = req_chan.bus_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_HBLANK, cycles: '0, line: '0};
      end else begin
         enable_ff    <= enable_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_chan.valid               = out_valid_ff;
   assign rsp_chan.mode                = result_ff.mode;
   assign rsp_chan.scan_line           = result_ff.scan_line;
   assign rsp_chan.vblank_interrupt    = result_ff.vblank_interrupt;
   assign rsp_chan.start_sprite_search = result_ff.start_sprite_search;
   assign rsp_chan.draw_line_now       = result_ff.draw_line_now;
   assign rsp_chan.access_region       = result_ff.access_region;
   assign rsp_chan.access_blocked      = result_ff.access_blocked;

   a_disabled_tick_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && !enable_ff && item_ff.operation == OP_TICK) |=>
      (state_ff.mode == MODE_HBLANK && state_ff.cycles == '0 && state_ff.line == '0))
      else $error("disabled tick did not clear the sequencer");

   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0({result_ff.vblank_interrupt,
                                 result_ff.start_sprite_search,
                                 result_ff.draw_line_now}))
      else $error("more than one timing pulse in one word");

   a_blocked_region: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.access_blocked) |->
      (result_ff.access_region == REGION_VRAM || result_ff.access_region == REGION_OAM))
      else $error("blocked access outside video or object memory");

   a_access_no_pulse: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.access_region != REGION_OTHER) |->
      !(result_ff.vblank_interrupt || result_ff.start_sprite_search ||
        result_ff.draw_line_now))
      else $error("timing pulse on an access check");

   a_state_held_without_step: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("sequencer state moved without a step");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lms_pkg::*;

   localparam int VIS_LINES  = 144;
   localparam int ALL_LINES  = 154;
   localparam int SEARCH_LEN = 80;
   localparam int RENDER_LEN = 172;
   localparam int HBLANK_LEN = 204;
   localparam int LINE_LEN   = 456;
   localparam int CYCLE_LIMIT = 400000;

   // mode timing and access check, one expected result word per item word
   class lcd_timing_model;
      mode_type            mode;
      logic [CYCLE_W-1:0]  cycles;
      logic [LINE_W-1:0]   line;
      bit                  enable;
      result_type          pending_results[$];
      int                  mismatches;

      function new();
         mode = MODE_HBLANK;
         cycles = '0;
         line = '0;
         enable = 1'b0;
         mismatches = 0;
      endfunction

      function void set_enable(bit v);
         enable = v;
      endfunction

      function void take_word(item_type w);
         result_type r;
         region_type reg_hit;
         r = '0;
         reg_hit = REGION_OTHER;
         case (op_type'(w.operation))
            OP_TICK: begin
               if (!enable) begin
                  mode = MODE_HBLANK;
                  cycles = '0;
                  line = '0;
               end else begin
                  cycles = cycles + CYCLE_W'(w.cycle_count);
                  case (mode)
                     MODE_SEARCH: begin
                        if (cycles >= SEARCH_LEN) begin
                           mode = MODE_RENDER;
                           cycles = '0;
                           r.start_sprite_search = 1'b1;
                        end
                     end
                     MODE_RENDER: begin
                        if (cycles >= RENDER_LEN) begin
                           mode = MODE_HBLANK;
                           cycles = '0;
                           r.draw_line_now = 1'b1;
                           line = line + 1'b1;
                        end
                     end
                     MODE_HBLANK: begin
                        if (cycles >= HBLANK_LEN) begin
                           cycles = '0;
                           if (line >= VIS_LINES) begin
                              mode = MODE_VBLANK;
                              r.vblank_interrupt = 1'b1;
                           end else begin
                              mode = MODE_SEARCH;
                           end
                        end
                     end
                     default: begin
                        if (cycles >= LINE_LEN) begin
                           cycles = '0;
                           line = line + 1'b1;
                        end
                        if (line >= ALL_LINES) begin
                           mode = MODE_SEARCH;
                           line = '0;
                        end
                     end
                  endcase
               end
            end
            OP_READ, OP_WRITE: begin
               if (w.bus_address >= VRAM_LO && w.bus_address <= VRAM_HI)
                  reg_hit = REGION_VRAM;
               else if (w.bus_address >= OAM_LO && w.bus_address <= OAM_HI)
                  reg_hit = REGION_OAM;
               r.access_region = reg_hit;
               if (enable && ((mode == MODE_SEARCH && reg_hit == REGION_OAM) ||
                              (mode == MODE_RENDER && reg_hit != REGION_OTHER)))
                  r.access_blocked = 1'b1;
            end
            default: ;
         endcase
         r.mode = mode;
         r.scan_line = line;
         pending_results.push_back(r);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_word(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            $error("result word with no expectation waiting");
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("mode", want.mode, got.mode);
         compare_field("scan_line", want.scan_line, got.scan_line);
         compare_field("vblank_interrupt", want.vblank_interrupt, got.vblank_interrupt);
         compare_field("start_sprite_search", want.start_sprite_search,
                       got.start_sprite_search);
         compare_field("draw_line_now", want.draw_line_now, got.draw_line_now);
         compare_field("access_region", want.access_region, got.access_region);
         compare_field("access_blocked", want.access_blocked, got.access_blocked);
      endfunction
   endclass

   logic clock;
   logic reset;
   int   elapsed_cycles;
   bit   req_steady;

   lcd_timing_model timing = new();
   item_type        seen_word;
   result_type      got_word;

   lms_req_if req_if();
   lms_rsp_if rsp_if();
   lms_csr_if csr_if();

   lcd_mode_sequencer_core #(
      .VISIBLE_LINES(VIS_LINES),
      .TOTAL_LINES(ALL_LINES),
      .SEARCH_CYCLES(SEARCH_LEN),
      .RENDER_CYCLES(RENDER_LEN),
      .HBLANK_CYCLES(HBLANK_LEN),
      .LINE_CYCLES(LINE_LEN)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      elapsed_cycles <= elapsed_cycles + 1;
      if (elapsed_cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            timing.set_enable(csr_if.display_enable);
         if (req_if.valid && req_if.ready) begin
            seen_word.operation = req_if.operation;
            seen_word.cycle_count = req_if.cycle_count;
            seen_word.bus_address = req_if.bus_address;
            timing.take_word(seen_word);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got_word.mode = rsp_if.mode;
            got_word.scan_line = rsp_if.scan_line;
            got_word.vblank_interrupt = rsp_if.vblank_interrupt;
            got_word.start_sprite_search = rsp_if.start_sprite_search;
            got_word.draw_line_now = rsp_if.draw_line_now;
            got_word.access_region = rsp_if.access_region;
            got_word.access_blocked = rsp_if.access_blocked;
            timing.check_word(got_word);
         end
      end
   end

   function automatic int draw_wait(bit steady);
      return steady ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic item_type random_item();
      item_type w;
      int pick;
      int apick;
      pick = $urandom_range(0, 99);
      if (pick < 78)
         w.operation = OP_TICK;
      else if (pick < 88)
         w.operation = OP_READ;
      else if (pick < 97)
         w.operation = OP_WRITE;
      else
         w.operation = OP_NONE;
      if ($urandom_range(0, 99) < 80)
         w.cycle_count = COUNT_W'($urandom_range(160, 255));
      else
         w.cycle_count = COUNT_W'($urandom_range(0, 255));
      apick = $urandom_range(0, 5);
      case (apick)
         0, 1: w.bus_address = ADDR_W'($urandom_range(VRAM_LO, VRAM_HI));
         2, 3: w.bus_address = ADDR_W'($urandom_range(OAM_LO, OAM_HI));
         4: begin
            case ($urandom_range(0, 3))
               0: w.bus_address = VRAM_LO - 1'b1;
               1: w.bus_address = VRAM_HI + 1'b1;
               2: w.bus_address = OAM_LO - 1'b1;
               default: w.bus_address = OAM_HI + 1'b1;
            endcase
         end
         default: w.bus_address = ADDR_W'($urandom_range(0, 65535));
      endcase
      return w;
   endfunction

   task automatic send_word(input op_type op, input logic [COUNT_W-1:0] cyc,
                            input logic [ADDR_W-1:0] addr);
      int gap;
      gap = draw_wait(req_steady);
      if (gap > 0) begin
         @(negedge clock) req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.operation <= op;
      req_if.cycle_count <= cyc;
      req_if.bus_address <= addr;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic write_enable(input bit v);
      @(negedge clock) req_if.valid <= 1'b0;
      while (timing.pending_results.size() != 0) @(negedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.display_enable <= v;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock) csr_if.valid <= 1'b0;
   endtask

   // receiver with random stalls and one long hold to back up the pipeline
   initial begin
      int wait_n;
      int taken;
      bit steady;
      rsp_if.ready = 1'b0;
      taken = 0;
      steady = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (taken % 40 == 0)
            steady = ($urandom_range(0, 3) == 0);
         wait_n = (taken == 500) ? 200 : draw_wait(steady);
         if (wait_n > 0) begin
            @(negedge clock) rsp_if.ready <= 1'b0;
            repeat (wait_n - 1) @(negedge clock);
         end
         @(negedge clock) rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         taken++;
      end
   end

   initial begin
      logic [ADDR_W-1:0] bound_addrs [10] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h9FFF,
                                              16'hA000, 16'hFDFF, 16'hFE00, 16'hFE9F,
                                              16'hFEA0, 16'hFFFF};
      bit phase_en [3] = '{1'b1, 1'b0, 1'b1};
      int phase_len [3] = '{1000, 80, 720};
      item_type w;
      int p;
      int i;
      reset = 1'b1;
      elapsed_cycles = 0;
      req_steady = 1'b0;
      req_if.valid = 1'b0;
      req_if.operation = OP_TICK;
      req_if.cycle_count = '0;
      req_if.bus_address = '0;
      csr_if.valid = 1'b0;
      csr_if.display_enable = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // display off: ticks hold at zero, accesses never blocked
      write_enable(1'b0);
      send_word(OP_TICK, 8'd255, 16'h0000);
      for (i = 0; i < 10; i++)
         send_word((i % 2) ? OP_WRITE : OP_READ, 8'hFF, bound_addrs[i]);
      send_word(OP_NONE, 8'hAA, 16'h5555);

      // display on: walk one line by hand across the thresholds
      write_enable(1'b1);
      send_word(OP_TICK, 8'd0, 16'hFFFF);
      send_word(OP_TICK, 8'd255, 16'h0000);
      send_word(OP_READ, 8'd0, OAM_LO);
      send_word(OP_WRITE, 8'd0, VRAM_LO);
      send_word(OP_TICK, 8'd80, 16'h0000);
      send_word(OP_READ, 8'd0, VRAM_HI);
      send_word(OP_WRITE, 8'd0, OAM_HI);
      send_word(OP_READ, 8'd0, 16'h1234);
      send_word(OP_TICK, 8'd171, 16'h0000);
      send_word(OP_TICK, 8'd1, 16'h0000);
      send_word(OP_NONE, 8'h55, 16'hAAAA);

      for (p = 0; p < 3; p++) begin
         write_enable(phase_en[p]);
         for (i = 0; i < phase_len[p]; i++) begin
            if (i % 40 == 0)
               req_steady = ($urandom_range(0, 3) == 0);
            w = random_item();
            send_word(op_type'(w.operation), w.cycle_count, w.bus_address);
         end
      end

      @(negedge clock) req_if.valid <= 1'b0;
      while (timing.pending_results.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (timing.pending_results.size() != 0)
         $error("%0d expected results never arrived", timing.pending_results.size());
      if (timing.mismatches == 0 && timing.pending_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: files.f
src/lms_pkg.sv
src/lms_if.sv
src/lms_region.sv
src/lms_step.sv
src/lcd_mode_sequencer_core.sv
tb/tb_top.sv
